### rtl/core/mevp_pkg.sv
package mevp_pkg;

    localparam int FIELD_W   = 12;
    localparam int CFG_W     = 12;
    localparam int MESH_ID_W = 4;
    localparam int SLOT_W    = 2;
    localparam int SLOTS     = 4;
    localparam int COMBO_W   = 2 * SLOT_W;

    localparam logic [CFG_W-1:0] THR_RESET = 12'd4;

    // extreme slots, in store order
    localparam logic [SLOT_W-1:0] SLOT_LX = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_LY = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_GX = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_GY = 2'd3;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_STORE,
        ST_START,
        ST_READ,
        ST_CMP,
        ST_OUT
    } mevp_state_t;

    // neighboring extremes that came from the same vertex
    typedef struct packed {
        logic lxly;
        logic lygx;
        logic gxgy;
    } mevp_same_t;

endpackage

### rtl/core/mevp_tracker.sv
module mevp_tracker
    import mevp_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vtx_en,
    input  logic [COORD_BITS-1:0] vtx_x,
    input  logic [COORD_BITS-1:0] vtx_y,
    input  logic                  mesh_end,
    input  logic [SLOT_W-1:0]     slot_sel,
    output logic [COORD_BITS-1:0] slot_x,
    output logic [COORD_BITS-1:0] slot_y,
    output logic                  slot_keep
);

    logic [COORD_BITS-1:0] ext_x_reg [SLOTS];
    logic [COORD_BITS-1:0] ext_y_reg [SLOTS];
    mevp_same_t            same_reg;
    mevp_same_t            same_next;
    logic                  in_mesh_reg;
    logic [SLOTS-1:0]      upd;

    function automatic logic joined(input logic up, input logic uq, input logic old);
        logic res;
        if (up || uq)
        begin
            res = up && uq;
        end
        else
        begin
            res = old;
        end
        return res;
    endfunction

    always_comb
    begin
        upd = '0;
        if (!in_mesh_reg)
        begin
            upd = '1;
        end
        else
        begin
            // greatest test only when the least test fails
            if (vtx_x < ext_x_reg[SLOT_LX])
            begin
                upd[SLOT_LX] = 1'b1;
            end
            else if (vtx_x > ext_x_reg[SLOT_GX])
            begin
                upd[SLOT_GX] = 1'b1;
            end
            if (vtx_y < ext_y_reg[SLOT_LY])
            begin
                upd[SLOT_LY] = 1'b1;
            end
            else if (vtx_y > ext_y_reg[SLOT_GY])
            begin
                upd[SLOT_GY] = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (!in_mesh_reg)
        begin
            same_next = '1;
        end
        else
        begin
            same_next.lxly = joined(upd[SLOT_LX], upd[SLOT_LY], same_reg.lxly);
            same_next.lygx = joined(upd[SLOT_LY], upd[SLOT_GX], same_reg.lygx);
            same_next.gxgy = joined(upd[SLOT_GX], upd[SLOT_GY], same_reg.gxgy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            same_reg    <= '0;
            in_mesh_reg <= 1'b0;
        end
        else if (vtx_en)
        begin
            same_reg    <= same_next;
            in_mesh_reg <= !mesh_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vtx_en)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                if (upd[k])
                begin
                    ext_x_reg[k] <= vtx_x;
                    ext_y_reg[k] <= vtx_y;
                end
            end
        end
    end

    assign slot_x = ext_x_reg[slot_sel];
    assign slot_y = ext_y_reg[slot_sel];

    always_comb
    begin
        unique case (slot_sel)
            SLOT_LX: slot_keep = 1'b1;
            SLOT_LY: slot_keep = !same_reg.lxly;
            SLOT_GX: slot_keep = !same_reg.lygx;
            SLOT_GY: slot_keep = !same_reg.gxgy;
            default: slot_keep = 1'b0;
        endcase
    end

endmodule

### rtl/core/mevp_store.sv
module mevp_store
    import mevp_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 25
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_a,
    output logic [DW-1:0] rd_data_b
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_a_reg;
    logic [DW-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### rtl/core/mevp_dist.sv
module mevp_dist
    import mevp_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic [2*COORD_BITS:0] ent_a,
    input  logic [2*COORD_BITS:0] ent_b,
    input  logic [CFG_W-1:0]      thr,
    output logic                  close
);

    localparam int CMP_W = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

    logic [COORD_BITS-1:0] ax, ay, bx, by;
    logic [COORD_BITS-1:0] dx, dy;
    logic                  keep_a, keep_b;

    // entry layout: keep, y, x
    assign ax     = ent_a[COORD_BITS-1:0];
    assign ay     = ent_a[2*COORD_BITS-1:COORD_BITS];
    assign keep_a = ent_a[2*COORD_BITS];
    assign bx     = ent_b[COORD_BITS-1:0];
    assign by     = ent_b[2*COORD_BITS-1:COORD_BITS];
    assign keep_b = ent_b[2*COORD_BITS];

    assign dx = (ax >= bx) ? (ax - bx) : (bx - ax);
    assign dy = (ay >= by) ? (ay - by) : (by - ay);

    assign close = keep_a && keep_b
                && (CMP_W'(dx) < CMP_W'(thr))
                && (CMP_W'(dy) < CMP_W'(thr));

endmodule

### rtl/core/mesh_extreme_vertex_proximity_unit.sv
// channel   | dir | tdata                              | tuser                       | tlast
// s_axis    | in  | vertex_x [11:0], vertex_y [23:12]  | end_of_batch [0]            | end_of_mesh
// m_axis    | out | mesh_a [3:0], mesh_b [7:4]         | pair_valid, adjacent, drop  | last
// cfg       | in  | cfg_wdata = gap_threshold, written when cfg_we is high
//
// vertices stream in without stalls while loading; a mesh that is stored adds one
// write per extreme slot (one store write port) with s_axis_tready low.
// at batch end each mesh pair walks all 16 slot combinations through one shared
// distance unit, each as a registered store read and then a compare, and the
// pair's result then waits in the output state; n meshes give n*(n-1)/2 pairs.
// reset clears the sequencer, counts and flags and sets gap_threshold to 4.
// m_axis holds its word until m_axis_tready; no input is taken until the batch
// has been fully delivered.
module mesh_extreme_vertex_proximity_unit
    import mevp_pkg::*;
#(
    parameter int MAX_MESHES = 8,
    parameter int COORD_BITS = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // vertex_x, vertex_y
    input  logic             s_axis_tlast,   // end_of_mesh
    input  logic [0:0]       s_axis_tuser,   // end_of_batch
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // mesh_a, mesh_b
    output logic             m_axis_tlast,   // last
    output logic [2:0]       m_axis_tuser,   // pair_valid, adjacent, meshes_dropped
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_MESHES);
    localparam int CNT_W = $clog2(MAX_MESHES + 1);
    localparam int AW    = IDX_W + SLOT_W;
    localparam int DEPTH = MAX_MESHES * SLOTS;
    localparam int DW    = 2 * COORD_BITS + 1;

    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_MESHES);
    localparam logic [CNT_W-1:0]   CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0]   CNT_TWO   = CNT_W'(2);
    localparam logic [COMBO_W-1:0] COMBO_END = '1;

    mevp_state_t state_reg, state_next;

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 ovf_reg, ovf_next;
    logic                 eob_reg, eob_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [IDX_W-1:0]     a_reg, a_next;
    logic [IDX_W-1:0]     b_reg, b_next;
    logic [COMBO_W-1:0]   ij_reg, ij_next;
    logic                 adj_reg, adj_next;
    logic [CFG_W-1:0]     thr_reg;

    logic [MESH_ID_W-1:0] oa_reg, oa_next;
    logic [MESH_ID_W-1:0] ob_reg, ob_next;
    logic                 opv_reg, opv_next;
    logic                 oadj_reg, oadj_next;
    logic                 odrop_reg, odrop_next;
    logic                 olast_reg, olast_next;

    logic                  s_acc, m_acc;
    logic                  in_eom, in_eob;
    logic [COORD_BITS-1:0] in_x, in_y;
    logic                  mem_we;
    logic [COORD_BITS-1:0] slot_x, slot_y;
    logic                  slot_keep;
    logic [DW-1:0]         rd_a, rd_b;
    logic                  close;
    logic                  b_at_end, a_at_end;

    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign m_acc  = m_axis_tvalid && m_axis_tready;
    assign in_x   = COORD_BITS'(s_axis_tdata[11:0]);
    assign in_y   = COORD_BITS'(s_axis_tdata[23:12]);
    assign in_eom = s_axis_tlast;
    assign in_eob = s_axis_tuser[0];

    assign b_at_end = (CNT_W'(b_reg) == cnt_reg - CNT_ONE);
    assign a_at_end = (CNT_W'(a_reg) == cnt_reg - CNT_TWO);

    mevp_tracker #(
        .COORD_BITS (COORD_BITS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_en    (s_acc),
        .vtx_x     (in_x),
        .vtx_y     (in_y),
        .mesh_end  (in_eom || in_eob),
        .slot_sel  (slot_reg),
        .slot_x    (slot_x),
        .slot_y    (slot_y),
        .slot_keep (slot_keep)
    );

    mevp_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .clk       (clk),
        .wr_en     (mem_we),
        .wr_addr   ({IDX_W'(cnt_reg), slot_reg}),
        .wr_data   ({slot_keep, slot_y, slot_x}),
        .rd_addr_a ({a_reg, ij_reg[COMBO_W-1:SLOT_W]}),
        .rd_addr_b ({b_reg, ij_reg[SLOT_W-1:0]}),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    mevp_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .ent_a (rd_a),
        .ent_b (rd_b),
        .thr   (thr_reg),
        .close (close)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_acc && (in_eom || in_eob))
                begin
                    if (cnt_reg < CNT_MAX)
                    begin
                        state_next = ST_STORE;
                    end
                    else if (in_eob)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_STORE:
            begin
                if (slot_reg == SLOT_GY)
                begin
                    state_next = eob_reg ? ST_START : ST_LOAD;
                end
            end
            ST_START:
            begin
                state_next = (cnt_reg < CNT_TWO) ? ST_OUT : ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (ij_reg == COMBO_END)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                if (m_acc)
                begin
                    state_next = olast_reg ? ST_LOAD : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        mem_we        = 1'b0;
        unique case (state_reg)
            ST_LOAD:  s_axis_tready = 1'b1;
            ST_STORE: mem_we        = 1'b1;
            ST_OUT:   m_axis_tvalid = 1'b1;
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        eob_next   = eob_reg;
        slot_next  = slot_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        ij_next    = ij_reg;
        adj_next   = adj_reg;
        oa_next    = oa_reg;
        ob_next    = ob_reg;
        opv_next   = opv_reg;
        oadj_next  = oadj_reg;
        odrop_next = odrop_reg;
        olast_next = olast_reg;
        case (state_reg)
            ST_LOAD:
            begin
                slot_next = SLOT_LX;
                if (s_acc)
                begin
                    eob_next = in_eob;
                    if ((in_eom || in_eob) && (cnt_reg >= CNT_MAX))
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_STORE:
            begin
                slot_next = slot_reg + SLOT_W'(1);
                if (slot_reg == SLOT_GY)
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end
            ST_START:
            begin
                a_next   = '0;
                b_next   = IDX_W'(1);
                ij_next  = '0;
                adj_next = 1'b0;
                if (cnt_reg < CNT_TWO)
                begin
                    // lone result of a batch with no pair
                    oa_next    = '0;
                    ob_next    = '0;
                    opv_next   = 1'b0;
                    oadj_next  = 1'b0;
                    odrop_next = ovf_reg;
                    olast_next = 1'b1;
                end
            end
            ST_CMP:
            begin
                adj_next = adj_reg || close;
                ij_next  = ij_reg + COMBO_W'(1);
                if (ij_reg == COMBO_END)
                begin
                    oa_next    = MESH_ID_W'(a_reg);
                    ob_next    = MESH_ID_W'(b_reg);
                    opv_next   = 1'b1;
                    oadj_next  = adj_reg || close;
                    odrop_next = ovf_reg;
                    olast_next = a_at_end && b_at_end;
                end
            end
            ST_OUT:
            begin
                if (m_acc)
                begin
                    if (olast_reg)
                    begin
                        cnt_next = '0;
                        ovf_next = 1'b0;
                    end
                    else
                    begin
                        ij_next  = '0;
                        adj_next = 1'b0;
                        if (b_at_end)
                        begin
                            a_next = a_reg + IDX_W'(1);
                            b_next = a_reg + IDX_W'(2);
                        end
                        else
                        begin
                            b_next = b_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                ij_next = ij_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            eob_reg   <= 1'b0;
            slot_reg  <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            ij_reg    <= '0;
            adj_reg   <= 1'b0;
            thr_reg   <= THR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            eob_reg   <= eob_next;
            slot_reg  <= slot_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            ij_reg    <= ij_next;
            adj_reg   <= adj_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        oa_reg    <= oa_next;
        ob_reg    <= ob_next;
        opv_reg   <= opv_next;
        oadj_reg  <= oadj_next;
        odrop_reg <= odrop_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tdata = {ob_reg, oa_reg};
    assign m_axis_tuser = {odrop_reg, oadj_reg, opv_reg};
    assign m_axis_tlast = olast_reg;

endmodule
